// ===== hw/rtl/pcmq_pkg.sv =====
// Shared types, constants and codes for the PCM16 take qualifier.
`default_nettype none
package pcmq_pkg;

    localparam int MAX_BYTES = 4194304;

    localparam int CNT_W  = 22;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX    = '1;
    localparam logic [CNT_W+3:0] BYTE_LIMIT = (CNT_W + 4)'(MAX_BYTES);

    localparam logic signed [15:0] CLIP_POS = 16'sd32760;
    localparam logic signed [15:0] CLIP_NEG = -16'sd32760;
    localparam logic signed [15:0] ACT_POS  = 16'sd104;
    localparam logic signed [15:0] ACT_NEG  = -16'sd104;

    localparam logic [15:0] RATE_24K = 16'd24000;
    localparam logic [15:0] RATE_44K = 16'd44100;
    localparam logic [15:0] RATE_48K = 16'd48000;

    localparam logic [1:0] CH_MONO   = 2'd1;
    localparam logic [1:0] CH_STEREO = 2'd2;

    localparam logic [9:0] MS_SCALE = 10'd1000;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        V_OK       = 3'd0,
        V_FORMAT   = 3'd1,
        V_DURATION = 3'd2,
        V_CLIPPED  = 3'd3,
        V_SILENT   = 3'd4,
        V_SILENCE  = 3'd5
    } t_verdict;

    typedef enum logic [2:0] {
        REG_CHANNELS = 3'd0,
        REG_RATE     = 3'd1,
        REG_SPEECH   = 3'd2,
        REG_MIN_MS   = 3'd3,
        REG_MAX_MS   = 3'd4,
        REG_LEAD_MS  = 3'd5,
        REG_TRAIL_MS = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCALE,
        B_CMP
    } t_bstate;

    typedef struct packed {
        logic [1:0]  channel_count;
        logic [15:0] sample_rate;
        logic        speech_mode;
        logic [13:0] min_duration_ms;
        logic [13:0] max_duration_ms;
        logic [8:0]  max_lead_silence_ms;
        logic [9:0]  max_trail_silence_ms;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] first;
        logic [CNT_W-1:0] last;
        logic             any_active;
        logic             clip_seen;
        logic             sat;
    } t_take;

endpackage
`default_nettype wire

// ===== hw/rtl/pcm16_take_qualifier_unit.sv =====
// Top level of the PCM16 take qualifier.
// Takes one interleaved 16-bit sample per clock while full is low, no gaps needed;
// the per-sample tracker updates its compares and counters per accepted word. A
// take summary enters a two-entry queue on the final sample; the judge takes one
// at a time. push stalls (full high) only while the queue holds two takes still
// waiting to be judged; the result register is held until popped. Configuration
// registers sit at byte addresses 0, 4, ... 24; the user must write them only
// between takes' verdicts, and the block itself does not enforce this.
`default_nettype none
module pcm16_take_qualifier_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [15:0]                 i_sample,
    input  wire logic                        i_final_req,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [2:0]                       o_verdict,
    output logic [pcmq_pkg::CNT_W-1:0]       o_frame_total,
    output logic [pcmq_pkg::CNT_W-1:0]       o_lead_frames,
    output logic [pcmq_pkg::CNT_W-1:0]       o_trail_frames,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pcmq_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pcmq_pkg::DATA_W-1:0] pwdata,
    output logic      [pcmq_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    pcmq_pkg::t_cfg  cfg;
    pcmq_pkg::t_take take_in, take_out;
    logic            take_push, q_pop, q_empty, accept;

    assign accept = push && !full;

    pcmq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pcmq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .i_final_req (i_final_req),
        .o_take_push (take_push),
        .o_take      (take_in)
    );

    pcmq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take_push),
        .i_take  (take_in),
        .i_pop   (q_pop),
        .o_take  (take_out),
        .o_full  (full),
        .o_empty (q_empty)
    );

    pcmq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_q_empty      (q_empty),
        .i_take         (take_out),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_verdict      (o_verdict),
        .o_frame_total  (o_frame_total),
        .o_lead_frames  (o_lead_frames),
        .o_trail_frames (o_trail_frames)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/pcmq_cfg.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none
module pcmq_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pcmq_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pcmq_pkg::DATA_W-1:0] pwdata,
    output logic      [pcmq_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output pcmq_pkg::t_cfg                  o_cfg
);

    pcmq_pkg::t_cfg     r_cfg;
    pcmq_pkg::t_reg_idx idx;
    logic               wr;

    assign idx    = pcmq_pkg::t_reg_idx'(paddr[4:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count        <= 2'd1;
            r_cfg.sample_rate          <= 16'd48000;
            r_cfg.speech_mode          <= 1'b0;
            r_cfg.min_duration_ms      <= 14'd100;
            r_cfg.max_duration_ms      <= 14'd15000;
            r_cfg.max_lead_silence_ms  <= 9'd500;
            r_cfg.max_trail_silence_ms <= 10'd1000;
        end else if (wr) begin
            case (idx)
                pcmq_pkg::REG_CHANNELS: r_cfg.channel_count        <= pwdata[1:0];
                pcmq_pkg::REG_RATE:     r_cfg.sample_rate          <= pwdata[15:0];
                pcmq_pkg::REG_SPEECH:   r_cfg.speech_mode          <= pwdata[0];
                pcmq_pkg::REG_MIN_MS:   r_cfg.min_duration_ms      <= pwdata[13:0];
                pcmq_pkg::REG_MAX_MS:   r_cfg.max_duration_ms      <= pwdata[13:0];
                pcmq_pkg::REG_LEAD_MS:  r_cfg.max_lead_silence_ms  <= pwdata[8:0];
                pcmq_pkg::REG_TRAIL_MS: r_cfg.max_trail_silence_ms <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            pcmq_pkg::REG_CHANNELS: prdata = 32'(r_cfg.channel_count);
            pcmq_pkg::REG_RATE:     prdata = 32'(r_cfg.sample_rate);
            pcmq_pkg::REG_SPEECH:   prdata = 32'(r_cfg.speech_mode);
            pcmq_pkg::REG_MIN_MS:   prdata = 32'(r_cfg.min_duration_ms);
            pcmq_pkg::REG_MAX_MS:   prdata = 32'(r_cfg.max_duration_ms);
            pcmq_pkg::REG_LEAD_MS:  prdata = 32'(r_cfg.max_lead_silence_ms);
            pcmq_pkg::REG_TRAIL_MS: prdata = 32'(r_cfg.max_trail_silence_ms);
            default:                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pcmq_front.sv =====
// Per-sample tracker: frame counting, clip and activity capture, take summary.
`default_nettype none
module pcmq_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pcmq_pkg::t_cfg i_cfg,
    input  wire logic           i_accept,
    input  wire logic [15:0]    i_sample,
    input  wire logic           i_final_req,
    output logic                o_take_push,
    output pcmq_pkg::t_take     o_take
);

    logic [pcmq_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [pcmq_pkg::CNT_W-1:0] r_first, n_first;
    logic [pcmq_pkg::CNT_W-1:0] r_last, n_last;
    logic r_phase, n_phase;
    logic r_frame_active, n_frame_active;
    logic r_clip, n_clip;
    logic r_any, n_any;

    logic signed [15:0]         s;
    logic                       stereo, completes, act, hit;
    logic [pcmq_pkg::CNT_W-1:0] frame;

    assign s         = i_sample;
    assign stereo    = (i_cfg.channel_count == pcmq_pkg::CH_STEREO);
    assign completes = !stereo || r_phase;
    assign act       = r_frame_active || (s > pcmq_pkg::ACT_POS) || (s < pcmq_pkg::ACT_NEG);
    assign hit       = completes && act;
    assign frame     = stereo ? (r_cnt >> 1) : r_cnt;

    always_comb begin
        n_clip         = r_clip || (s >= pcmq_pkg::CLIP_POS) || (s <= pcmq_pkg::CLIP_NEG);
        n_first        = (hit && !r_any) ? frame : r_first;
        n_last         = hit ? frame : r_last;
        n_any          = r_any || hit;
        n_frame_active = completes ? 1'b0 : act;
        n_phase        = stereo ? !r_phase : 1'b0;
        n_cnt          = (r_cnt < pcmq_pkg::CNT_MAX) ? r_cnt + 1'b1 : r_cnt;
    end

    assign o_take_push       = i_accept && i_final_req;
    assign o_take.n          = n_cnt;
    assign o_take.first      = n_first;
    assign o_take.last       = n_last;
    assign o_take.any_active = n_any;
    assign o_take.clip_seen  = n_clip;
    assign o_take.sat        = (r_cnt >= pcmq_pkg::CNT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_final_req)) begin
            r_cnt          <= '0;
            r_first        <= '0;
            r_last         <= '0;
            r_phase        <= 1'b0;
            r_frame_active <= 1'b0;
            r_clip         <= 1'b0;
            r_any          <= 1'b0;
        end else if (i_accept) begin
            r_cnt          <= n_cnt;
            r_first        <= n_first;
            r_last         <= n_last;
            r_phase        <= n_phase;
            r_frame_active <= n_frame_active;
            r_clip         <= n_clip;
            r_any          <= n_any;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pcmq_queue.sv =====
// Short register queue of take summaries between the tracker and the judge.
`default_nettype none
module pcmq_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire pcmq_pkg::t_take i_take,
    input  wire logic            i_pop,
    output pcmq_pkg::t_take      o_take,
    output logic                 o_full,
    output logic                 o_empty
);

    pcmq_pkg::t_take                 r_mem [pcmq_pkg::QDEPTH];
    logic [pcmq_pkg::QPTR_W-1:0]     r_wr, r_rd;
    logic [pcmq_pkg::QCNT_W-1:0]     r_cnt;
    logic                            do_push, do_pop;

    assign o_full  = (r_cnt == pcmq_pkg::QCNT_W'(pcmq_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_take  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == pcmq_pkg::QPTR_W'(pcmq_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == pcmq_pkg::QPTR_W'(pcmq_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/pcmq_back.sv =====
// Verdict judge: format, duration, clip, activity and silence checks, and the result register.
`default_nettype none
module pcmq_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pcmq_pkg::t_cfg              i_cfg,
    input  wire logic                        i_q_empty,
    input  wire pcmq_pkg::t_take             i_take,
    output logic                             o_q_pop,
    input  wire logic                        i_pop,
    output logic                             o_empty,
    output logic [2:0]                       o_verdict,
    output logic [pcmq_pkg::CNT_W-1:0]       o_frame_total,
    output logic [pcmq_pkg::CNT_W-1:0]       o_lead_frames,
    output logic [pcmq_pkg::CNT_W-1:0]       o_trail_frames
);

    pcmq_pkg::t_bstate r_state, n_state;

    logic [pcmq_pkg::CNT_W-1:0] r_frames, r_lead, r_trail;
    logic                       r_fmt_bad, r_clip, r_any;
    logic [29:0]                r_min_p, r_max_p;
    logic [24:0]                r_lead_p;
    logic [25:0]                r_trail_p;
    logic [31:0]                r_f1000, r_l1000, r_t1000;

    logic                       r_out_valid;
    pcmq_pkg::t_verdict         r_verdict;
    logic [pcmq_pkg::CNT_W-1:0] r_out_frames, r_out_lead, r_out_trail;

    logic                       stereo, rate_ok, ch_ok, fmt_bad;
    logic [pcmq_pkg::CNT_W-1:0] frames, lead, trail;
    logic                       out_free, load_out, load_s1;
    pcmq_pkg::t_verdict         verdict;

    assign stereo  = (i_cfg.channel_count == pcmq_pkg::CH_STEREO);
    assign ch_ok   = (i_cfg.channel_count == pcmq_pkg::CH_MONO) || stereo;
    assign rate_ok = (i_cfg.sample_rate == pcmq_pkg::RATE_24K) ||
                     (i_cfg.sample_rate == pcmq_pkg::RATE_44K) ||
                     (i_cfg.sample_rate == pcmq_pkg::RATE_48K);

    always_comb begin
        frames  = stereo ? (i_take.n >> 1) : i_take.n;
        lead    = i_take.any_active ? i_take.first : frames;
        trail   = (i_take.any_active && (i_take.last < frames)) ?
                  frames - i_take.last - 1'b1 : '0;
        fmt_bad = !ch_ok || (i_cfg.speech_mode && !(i_cfg.channel_count == pcmq_pkg::CH_MONO))
                  || !rate_ok || i_take.sat
                  || ({3'b0, i_take.n, 1'b0} > pcmq_pkg::BYTE_LIMIT)
                  || (stereo && i_take.n[0]);
    end

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pcmq_pkg::B_IDLE:  if (!i_q_empty) n_state = pcmq_pkg::B_SCALE;
            pcmq_pkg::B_SCALE: n_state = pcmq_pkg::B_CMP;
            pcmq_pkg::B_CMP:   if (out_free) n_state = pcmq_pkg::B_IDLE;
            default:           n_state = pcmq_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        load_s1  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            pcmq_pkg::B_IDLE: begin
                o_q_pop = !i_q_empty;
                load_s1 = !i_q_empty;
            end
            pcmq_pkg::B_CMP:  load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (r_fmt_bad) begin
            verdict = pcmq_pkg::V_FORMAT;
        end else if ((r_f1000 < 32'(r_min_p)) || (r_f1000 > 32'(r_max_p))) begin
            verdict = pcmq_pkg::V_DURATION;
        end else if (r_clip) begin
            verdict = pcmq_pkg::V_CLIPPED;
        end else if (!r_any) begin
            verdict = pcmq_pkg::V_SILENT;
        end else if ((r_l1000 > 32'(r_lead_p)) || (r_t1000 > 32'(r_trail_p))) begin
            verdict = pcmq_pkg::V_SILENCE;
        end else begin
            verdict = pcmq_pkg::V_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcmq_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_frames  <= frames;
            r_lead    <= lead;
            r_trail   <= trail;
            r_fmt_bad <= fmt_bad;
            r_clip    <= i_take.clip_seen;
            r_any     <= i_take.any_active;
            r_min_p   <= 30'(i_cfg.min_duration_ms) * 30'(i_cfg.sample_rate);
            r_max_p   <= 30'(i_cfg.max_duration_ms) * 30'(i_cfg.sample_rate);
            r_lead_p  <= 25'(i_cfg.max_lead_silence_ms) * 25'(i_cfg.sample_rate);
            r_trail_p <= 26'(i_cfg.max_trail_silence_ms) * 26'(i_cfg.sample_rate);
        end
        if (r_state == pcmq_pkg::B_SCALE) begin
            r_f1000 <= 32'(r_frames) * 32'(pcmq_pkg::MS_SCALE);
            r_l1000 <= 32'(r_lead) * 32'(pcmq_pkg::MS_SCALE);
            r_t1000 <= 32'(r_trail) * 32'(pcmq_pkg::MS_SCALE);
        end
        if (load_out) begin
            r_verdict    <= verdict;
            r_out_frames <= r_frames;
            r_out_lead   <= r_lead;
            r_out_trail  <= r_trail;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_frame_total  = r_out_frames;
    assign o_lead_frames  = r_out_lead;
    assign o_trail_frames = r_out_trail;

endmodule
`default_nettype wire

// ===== hw/rtl/pcmq_checker.sv =====
// Port-level checks for the PCM16 take qualifier, bound to the top level.
`default_nettype none
module pcmq_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        empty,
    input wire logic                        pop,
    input wire logic [2:0]                  o_verdict,
    input wire logic [pcmq_pkg::CNT_W-1:0]  o_frame_total,
    input wire logic [pcmq_pkg::CNT_W-1:0]  o_lead_frames,
    input wire logic [pcmq_pkg::CNT_W-1:0]  o_trail_frames
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_verdict) && $stable(o_frame_total)))
        else $error("waiting result word changed before pop");

    a_silent_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_verdict == pcmq_pkg::V_SILENT) |->
        (o_lead_frames == o_frame_total && o_trail_frames == '0))
        else $error("silent take with inconsistent lead or trail");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_verdict <= 3'(pcmq_pkg::V_SILENCE)))
        else $error("verdict code out of range");

endmodule

bind pcm16_take_qualifier_unit pcmq_checker u_pcmq_checker (.*);
`default_nettype wire

// ===== tb/pcm16_take_qualifier_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the PCM16 take qualifier: directed table, then random takes.
module pcm16_take_qualifier_unit_tb;
    import pcmq_pkg::*;

    localparam int LIMIT      = 500000;
    localparam int SETTLE     = 8;
    localparam int DRAIN      = 20;
    localparam int SOAK       = 300;
    localparam int RAND_ITEMS = 650;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        t_verdict         verdict;
        logic [CNT_W-1:0] frames;
        logic [CNT_W-1:0] lead;
        logic [CNT_W-1:0] trail;
    } take_report_t;

    typedef struct {
        bit           is_cfg;
        logic [2:0]   ridx;
        logic [31:0]  val;
        logic [15:0]  smp;
        bit           fin;
        bit           typed;
        take_report_t want;
    } plan_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [15:0]        i_sample = '0;
    logic               i_final_req = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [2:0]         o_verdict;
    logic [CNT_W-1:0]   o_frame_total;
    logic [CNT_W-1:0]   o_lead_frames;
    logic [CNT_W-1:0]   o_trail_frames;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    pcm16_take_qualifier_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_sample(i_sample), .i_final_req(i_final_req),
        .empty(empty), .pop(pop),
        .o_verdict(o_verdict), .o_frame_total(o_frame_total),
        .o_lead_frames(o_lead_frames), .o_trail_frames(o_trail_frames),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    t_cfg             cfg;
    logic [CNT_W-1:0] sample_cnt;
    logic [CNT_W-1:0] first_frame;
    logic [CNT_W-1:0] last_frame;
    bit               odd_phase;
    bit               pend_active;
    bit               clipped;
    bit               heard;

    take_report_t reports_due[$];
    plan_row_t    plan[$];
    take_report_t none_due;
    int           fails = 0;
    int           items_sent = 0;
    int           cycle_cnt = 0;
    bit           tx_burst = 1'b0;
    bit           rx_burst = 1'b0;
    bit           soak_req = 1'b0;
    bit           soaked = 1'b0;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] loud_sample();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            v = $urandom_range(32760, 32768);
            return $urandom_range(0, 1) ? 16'(v) : 16'(-v);
        end
        return 16'($urandom());
    endfunction

    function automatic logic [15:0] quiet_sample();
        return 16'($urandom_range(0, 208) - 104);
    endfunction

    function automatic void clear_take_state();
        sample_cnt  = '0;
        first_frame = '0;
        last_frame  = '0;
        odd_phase   = 1'b0;
        pend_active = 1'b0;
        clipped     = 1'b0;
        heard       = 1'b0;
    endfunction

    function automatic void plan_cfg(logic [2:0] idx, logic [31:0] val);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.ridx   = idx;
        row.val    = val;
        row.smp    = '0;
        row.fin    = 1'b0;
        row.typed  = 1'b0;
        plan.push_back(row);
    endfunction

    function automatic void plan_smp(logic [15:0] s, bit fin);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.smp    = s;
        row.fin    = fin;
        row.typed  = 1'b0;
        plan.push_back(row);
    endfunction

    function automatic void plan_take(logic [15:0] s, t_verdict v, int ft, int lf, int tf);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.smp    = s;
        row.fin    = 1'b1;
        row.typed  = 1'b1;
        row.want   = '{v, CNT_W'(ft), CNT_W'(lf), CNT_W'(tf)};
        plan.push_back(row);
    endfunction

    task automatic qualify_sample(input logic [15:0] raw, input logic fin,
                                  output bit made, output take_report_t rep);
        int               s;
        int               mag;
        bit               stereo;
        bit               completes;
        bit               act;
        bit               oversize;
        bit               rate_ok;
        bit               fmt_bad;
        logic [CNT_W-1:0] fr;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] frames;
        logic [CNT_W-1:0] lead;
        logic [CNT_W-1:0] trail;
        longint unsigned  rate;
        longint unsigned  f1000;
        s = int'($signed(raw));
        mag = (s < 0) ? -s : s;
        stereo = (cfg.channel_count == CH_STEREO);
        completes = !stereo || odd_phase;
        act = pend_active || (mag > int'(ACT_POS));
        if (mag >= int'(CLIP_POS)) clipped = 1'b1;
        if (completes) begin
            fr = stereo ? (sample_cnt >> 1) : sample_cnt;
            if (act) begin
                if (!heard) first_frame = fr;
                heard = 1'b1;
                last_frame = fr;
            end
            pend_active = 1'b0;
        end else begin
            pend_active = act;
        end
        odd_phase = stereo ? !odd_phase : 1'b0;
        oversize = (sample_cnt == CNT_MAX);
        if (!oversize) sample_cnt++;
        made = fin;
        if (!fin) return;

        n = sample_cnt;
        frames = stereo ? (n >> 1) : n;
        if (heard) begin
            lead  = first_frame;
            trail = (last_frame < frames) ? frames - last_frame - 1'b1 : '0;
        end else begin
            lead  = frames;
            trail = '0;
        end
        rate = 64'(cfg.sample_rate);
        rate_ok = (cfg.sample_rate == RATE_24K) || (cfg.sample_rate == RATE_44K) ||
                  (cfg.sample_rate == RATE_48K);
        oversize = oversize || (64'(n) * 2 > 64'(MAX_BYTES));
        fmt_bad = !(cfg.channel_count == CH_MONO || cfg.channel_count == CH_STEREO) ||
                  (cfg.speech_mode && cfg.channel_count != CH_MONO) || !rate_ok ||
                  oversize || (stereo && n[0]);
        f1000 = 64'(frames) * 64'(MS_SCALE);
        if (fmt_bad)
            rep.verdict = V_FORMAT;
        else if (f1000 < 64'(cfg.min_duration_ms) * rate ||
                 f1000 > 64'(cfg.max_duration_ms) * rate)
            rep.verdict = V_DURATION;
        else if (clipped)
            rep.verdict = V_CLIPPED;
        else if (!heard)
            rep.verdict = V_SILENT;
        else if (64'(lead) * 64'(MS_SCALE) > 64'(cfg.max_lead_silence_ms) * rate ||
                 64'(trail) * 64'(MS_SCALE) > 64'(cfg.max_trail_silence_ms) * rate)
            rep.verdict = V_SILENCE;
        else
            rep.verdict = V_OK;
        rep.frames = frames;
        rep.lead   = lead;
        rep.trail  = trail;
        clear_take_state();
    endtask

    task automatic send(input logic [15:0] s, input logic fin, input bit typed,
                        input take_report_t want);
        int           gap;
        bit           made;
        take_report_t rep;
        gap = tx_burst ? 0 : idle_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_sample <= s;
        i_final_req <= fin;
        do @(posedge i_clk); while (full);
        qualify_sample(s, fin, made, rep);
        if (made) reports_due.push_back(typed ? want : rep);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_CHANNELS: cfg.channel_count        = val[1:0];
            REG_RATE:     cfg.sample_rate          = val[15:0];
            REG_SPEECH:   cfg.speech_mode          = val[0];
            REG_MIN_MS:   cfg.min_duration_ms      = val[13:0];
            REG_MAX_MS:   cfg.max_duration_ms      = val[13:0];
            REG_LEAD_MS:  cfg.max_lead_silence_ms  = val[8:0];
            REG_TRAIL_MS: cfg.max_trail_silence_ms = val[9:0];
            default: ;
        endcase
    endtask

    task automatic bus_idle();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic shuffle_settings();
        int r;
        r = $urandom_range(0, 99);
        write_reg(REG_CHANNELS, r < 45 ? CH_MONO : r < 90 ? CH_STEREO : r < 95 ? 0 : 3);
        r = $urandom_range(0, 99);
        write_reg(REG_RATE, r < 30 ? RATE_24K : r < 55 ? RATE_44K : r < 85 ? RATE_48K :
                            $urandom_range(0, 65535));
        write_reg(REG_SPEECH, $urandom_range(0, 99) < 15);
        r = $urandom_range(0, 99);
        write_reg(REG_MIN_MS, r < 70 ? 0 : r < 76 ? 1 : r < 82 ? 100 : r < 88 ? 15000 :
                              r < 94 ? 16383 : $urandom_range(0, 16383));
        r = $urandom_range(0, 99);
        write_reg(REG_MAX_MS, r < 35 ? 15000 : r < 65 ? 16383 : $urandom_range(0, 3));
        r = $urandom_range(0, 99);
        write_reg(REG_LEAD_MS, r < 75 ? $urandom_range(0, 2) : r < 88 ? 500 : 511);
        r = $urandom_range(0, 99);
        write_reg(REG_TRAIL_MS, r < 75 ? $urandom_range(0, 2) : r < 88 ? 1000 : 1023);
        if ($urandom_range(0, 4) == 0) write_reg(REG_UNUSED, $urandom());
        bus_idle();
    endtask

    task automatic send_take(input int mode);
        int          r;
        int          frames;
        int          spc;
        int          total;
        int          lead_q;
        int          trail_q;
        logic [15:0] s;
        r = $urandom_range(0, 99);
        frames = r < 80 ? $urandom_range(1, 20) : r < 98 ? $urandom_range(21, 80) :
                 $urandom_range(81, 300);
        spc = (cfg.channel_count == CH_STEREO) ? 2 : 1;
        total = frames * spc;
        if ($urandom_range(0, 9) == 0) total = (total > 1) ? total - 1 : total + 1;
        lead_q = $urandom_range(0, total);
        trail_q = $urandom_range(0, total - lead_q);
        for (int k = 0; k < total; k++) begin
            if (mode == 2)
                s = loud_sample();
            else if (mode == 1 || k < lead_q || k >= total - trail_q)
                s = quiet_sample();
            else
                s = loud_sample();
            send(s, k == total - 1, 1'b0, none_due);
            items_sent++;
        end
    endtask

    task automatic check_report();
        take_report_t want;
        if (reports_due.size() == 0) begin
            $error("result word with no take pending");
            fails++;
            return;
        end
        want = reports_due.pop_front();
        if (o_verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, o_verdict);
            fails++;
        end
        if (o_frame_total !== want.frames) begin
            $error("frame_total: expected %0d, got %0d", want.frames, o_frame_total);
            fails++;
        end
        if (o_lead_frames !== want.lead) begin
            $error("lead_frames: expected %0d, got %0d", want.lead, o_lead_frames);
            fails++;
        end
        if (o_trail_frames !== want.trail) begin
            $error("trail_frames: expected %0d, got %0d", want.trail, o_trail_frames);
            fails++;
        end
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                check_report();
                stall_left = rx_burst ? 0 : idle_len();
            end
            if (soak_req && !soaked) begin
                soaked = 1'b1;
                stall_left = SOAK;
            end
            if ($urandom_range(0, 255) == 0) rx_burst = !rx_burst;
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int ntakes;
        int phase;
        int r;
        cfg.channel_count        = CH_MONO;
        cfg.sample_rate          = RATE_48K;
        cfg.speech_mode          = 1'b0;
        cfg.min_duration_ms      = 14'd100;
        cfg.max_duration_ms      = 14'd15000;
        cfg.max_lead_silence_ms  = 9'd500;
        cfg.max_trail_silence_ms = 10'd1000;
        clear_take_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan_take(16'h0000, V_DURATION, 1, 1, 0);
        plan_take(16'h7FFF, V_DURATION, 1, 0, 0);
        plan_cfg(REG_MIN_MS, 0);
        plan_take(16'h8000, V_CLIPPED, 1, 0, 0);
        plan_take(16'sd32760, V_CLIPPED, 1, 0, 0);
        plan_take(-16'sd32759, V_OK, 1, 0, 0);
        plan_take(16'sd104, V_SILENT, 1, 1, 0);
        plan_take(-16'sd105, V_OK, 1, 0, 0);
        plan_cfg(REG_LEAD_MS, 0);
        plan_smp(16'sd0, 1'b0);
        plan_take(16'sd200, V_SILENCE, 2, 1, 0);
        plan_cfg(REG_LEAD_MS, 500);
        plan_cfg(REG_TRAIL_MS, 0);
        plan_smp(16'sd300, 1'b0);
        plan_take(16'sd0, V_SILENCE, 2, 0, 1);
        plan_cfg(REG_CHANNELS, CH_STEREO);
        plan_smp(16'sd0, 1'b0);
        plan_take(16'sd500, V_OK, 1, 0, 0);
        plan_take(16'sd500, V_FORMAT, 0, 0, 0);
        plan_cfg(REG_SPEECH, 1);
        plan_smp(16'sd0, 1'b0);
        plan_take(16'sd0, V_FORMAT, 1, 1, 0);
        plan_cfg(REG_SPEECH, 0);
        plan_cfg(REG_CHANNELS, 3);
        plan_take(16'sd200, V_FORMAT, 1, 0, 0);
        plan_cfg(REG_CHANNELS, CH_MONO);
        plan_cfg(REG_RATE, 24001);
        plan_take(16'sd0, V_FORMAT, 1, 1, 0);
        plan_cfg(REG_RATE, RATE_44K);
        plan_cfg(REG_MAX_MS, 0);
        plan_take(16'sd200, V_DURATION, 1, 0, 0);
        plan_cfg(REG_MAX_MS, 16383);
        plan_cfg(REG_UNUSED, 32'hFFFF_FFFF);
        plan_smp(16'sd0, 1'b0);
        plan_smp(16'sd0, 1'b0);
        plan_smp(16'sd0, 1'b0);
        plan_smp(16'sd300, 1'b0);
        plan_cfg(REG_CHANNELS, CH_STEREO);
        plan_smp(16'sd0, 1'b0);
        plan_smp(16'sd0, 1'b1);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].ridx, plan[i].val);
                bus_idle();
            end else begin
                send(plan[i].smp, plan[i].fin, plan[i].typed, plan[i].want);
            end
        end

        phase = 0;
        while (items_sent < RAND_ITEMS) begin
            settle();
            shuffle_settings();
            tx_burst = ($urandom_range(0, 3) == 0);
            ntakes = $urandom_range(3, 6);
            if (phase == 2) begin
                tx_burst = 1'b1;
                ntakes = 8;
                soak_req <= 1'b1;
            end
            repeat (ntakes) begin
                r = $urandom_range(0, 99);
                send_take(r < 80 ? 0 : r < 90 ? 1 : 2);
            end
            phase++;
        end

        settle();
        repeat (DRAIN) @(posedge i_clk);
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
